// ----- sv/tch_pkg.sv -----
// tch_pkg: shared types, widths and the arctangent table for the tilt
// compensated heading core. No dependencies.

package tch_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ATAN_LEN          = 24;

  // cross product of two 16-bit vectors needs 33 bits signed
  localparam int unsigned E_W  = 33;
  // sum of three squares of 16-bit values
  localparam int unsigned S_W  = 32;
  // square root of the sum scaled by 2^30
  localparam int unsigned R_W  = 31;
  // unit component magnitude, 15 fraction bits, can reach 1.0
  localparam int unsigned Q_W  = 16;
  localparam int unsigned U_W  = 17;
  // north components and the projection on the front axis
  localparam int unsigned N_W  = 51;
  localparam int unsigned XY_W = 64;
  // cordic datapath and angle accumulator
  localparam int unsigned CX_W = 34;
  localparam int unsigned Z_W  = 32;

  typedef enum logic [1:0] {
    REG_FRONT_X = 2'd0,
    REG_FRONT_Y = 2'd1,
    REG_FRONT_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [E_W-1:0] ex;
    logic signed [E_W-1:0] ey;
    logic signed [E_W-1:0] ez;
    logic                  deg;
  } side_t;

  typedef struct packed {
    logic kill;
    logic deg;
  } flag_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [Z_W-1:0] atan_angle(input logic [4:0] idx);
    logic [Z_W-1:0] ang;
    case (idx)
      5'd0:  ang = 32'h20000000;
      5'd1:  ang = 32'h12E4051E;
      5'd2:  ang = 32'h09FB385B;
      5'd3:  ang = 32'h051111D4;
      5'd4:  ang = 32'h028B0D43;
      5'd5:  ang = 32'h0145D7E1;
      5'd6:  ang = 32'h00A2F61E;
      5'd7:  ang = 32'h00517C55;
      5'd8:  ang = 32'h0028BE53;
      5'd9:  ang = 32'h00145F2F;
      5'd10: ang = 32'h000A2F98;
      5'd11: ang = 32'h000517CC;
      5'd12: ang = 32'h00028BE6;
      5'd13: ang = 32'h000145F3;
      5'd14: ang = 32'h0000A2FA;
      5'd15: ang = 32'h0000517D;
      5'd16: ang = 32'h000028BE;
      5'd17: ang = 32'h0000145F;
      5'd18: ang = 32'h00000A30;
      5'd19: ang = 32'h00000518;
      5'd20: ang = 32'h0000028C;
      5'd21: ang = 32'h00000146;
      5'd22: ang = 32'h000000A3;
      5'd23: ang = 32'h00000051;
      default: ang = '0;
    endcase
    return ang;
  endfunction

endpackage

// ----- sv/tch_unorm.sv -----
// tch_unorm: pipelined normalizer for the acceleration vector, one root bit
// per stage followed by one quotient bit per stage. Depends on tch_pkg.

module tch_unorm import tch_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [S_W-1:0]        sum_sq_i,
  input  logic signed [15:0]    a_x_i,
  input  logic signed [15:0]    a_y_i,
  input  logic signed [15:0]    a_z_i,
  input  side_t                 side_i,
  output logic                  valid_o,
  output logic signed [U_W-1:0] u_x_o,
  output logic signed [U_W-1:0] u_y_o,
  output logic signed [U_W-1:0] u_z_o,
  output side_t                 side_o
);

  localparam int unsigned SQ   = R_W;
  localparam int unsigned RM_W = 64;
  localparam int unsigned DV_W = 47;

  typedef struct packed {
    side_t             side;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } carry_t;

  // square root section
  logic [RM_W-1:0] sq_rem_q  [SQ+1];
  logic [R_W-1:0]  sq_root_q [SQ+1];
  carry_t          sq_c_q    [SQ+1];
  logic            sq_v_q    [SQ+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en_i) begin
      sq_v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_rem_q[0]  <= {2'b00, sum_sq_i, 30'd0};
      sq_root_q[0] <= '0;
      sq_c_q[0]    <= '{side: side_i, ax: a_x_i, ay: a_y_i, az: a_z_i};
    end
  end

  for (genvar g = 1; g <= SQ; g++) begin : g_sq
    localparam int unsigned B = SQ - g;
    logic [RM_W-1:0] trial;
    logic            ge;

    assign trial = (RM_W'(sq_root_q[g-1]) << (B + 1)) + (RM_W'(1) << (2 * B));
    assign ge    = sq_rem_q[g-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[g] <= 1'b0;
      end else if (en_i) begin
        sq_v_q[g] <= sq_v_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_rem_q[g]  <= ge ? sq_rem_q[g-1] - trial : sq_rem_q[g-1];
        sq_root_q[g] <= ge ? (sq_root_q[g-1] | (R_W'(1) << B)) : sq_root_q[g-1];
        sq_c_q[g]    <= sq_c_q[g-1];
      end
    end
  end

  // division section: |a_i| * 2^30 + r/2 divided by r
  logic [2:0][DV_W-1:0] dv_rem_q [Q_W+1];
  logic [2:0][Q_W-1:0]  dv_quo_q [Q_W+1];
  logic [R_W-1:0]       dv_r_q   [Q_W+1];
  carry_t               dv_c_q   [Q_W+1];
  logic                 dv_v_q   [Q_W+1];

  logic [2:0][15:0]     a_mag;
  logic [2:0][DV_W-1:0] num_d;

  always_comb begin
    a_mag[0] = sq_c_q[SQ].ax[15] ? 16'($unsigned(-sq_c_q[SQ].ax)) : 16'($unsigned(sq_c_q[SQ].ax));
    a_mag[1] = sq_c_q[SQ].ay[15] ? 16'($unsigned(-sq_c_q[SQ].ay)) : 16'($unsigned(sq_c_q[SQ].ay));
    a_mag[2] = sq_c_q[SQ].az[15] ? 16'($unsigned(-sq_c_q[SQ].az)) : 16'($unsigned(sq_c_q[SQ].az));
    for (int k = 0; k < 3; k++) begin
      num_d[k] = {1'b0, a_mag[k], 30'd0} + DV_W'(sq_root_q[SQ] >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_v_q[0] <= sq_v_q[SQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_rem_q[0] <= num_d;
      dv_quo_q[0] <= '0;
      dv_r_q[0]   <= sq_root_q[SQ];
      dv_c_q[0]   <= sq_c_q[SQ];
    end
  end

  for (genvar g = 1; g <= Q_W; g++) begin : g_dv
    localparam int unsigned B = Q_W - g;
    logic [DV_W-1:0]      dsr;
    logic [2:0][DV_W-1:0] rem_d;
    logic [2:0][Q_W-1:0]  quo_d;

    assign dsr = DV_W'(dv_r_q[g-1]) << B;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        if (dv_rem_q[g-1][k] >= dsr) begin
          rem_d[k] = dv_rem_q[g-1][k] - dsr;
          quo_d[k] = dv_quo_q[g-1][k] | (Q_W'(1) << B);
        end else begin
          rem_d[k] = dv_rem_q[g-1][k];
          quo_d[k] = dv_quo_q[g-1][k];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[g] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[g] <= dv_v_q[g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_rem_q[g] <= rem_d;
        dv_quo_q[g] <= quo_d;
        dv_r_q[g]   <= dv_r_q[g-1];
        dv_c_q[g]   <= dv_c_q[g-1];
      end
    end
  end

  // sign back on
  logic                  out_v_q;
  logic signed [U_W-1:0] u_x_q, u_y_q, u_z_q;
  side_t                 side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= dv_v_q[Q_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_x_q  <= dv_c_q[Q_W].ax[15] ? -$signed(U_W'(dv_quo_q[Q_W][0]))
                                   :  $signed(U_W'(dv_quo_q[Q_W][0]));
      u_y_q  <= dv_c_q[Q_W].ay[15] ? -$signed(U_W'(dv_quo_q[Q_W][1]))
                                   :  $signed(U_W'(dv_quo_q[Q_W][1]));
      u_z_q  <= dv_c_q[Q_W].az[15] ? -$signed(U_W'(dv_quo_q[Q_W][2]))
                                   :  $signed(U_W'(dv_quo_q[Q_W][2]));
      side_q <= dv_c_q[Q_W].side;
    end
  end

  assign valid_o = out_v_q;
  assign u_x_o   = u_x_q;
  assign u_y_o   = u_y_q;
  assign u_z_o   = u_z_q;
  assign side_o  = side_q;

endmodule

// ----- sv/tch_cordic.sv -----
// tch_cordic: vectoring cordic, one micro-rotation per register stage.
// Depends on tch_pkg for widths, flags and the arctangent table.

module tch_cordic import tch_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [CX_W-1:0] x_i,
  input  logic signed [CX_W-1:0] y_i,
  input  logic [Z_W-1:0]         z_i,
  input  flag_t                  flag_i,
  output logic                   valid_o,
  output logic [Z_W-1:0]         z_o,
  output flag_t                  flag_o
);

  logic signed [CX_W-1:0] x_q [STAGES];
  logic signed [CX_W-1:0] y_q [STAGES];
  logic [Z_W-1:0]         z_q [STAGES];
  flag_t                  f_q [STAGES];
  logic                   v_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_rot
    logic signed [CX_W-1:0] xi, yi, xs, ys;
    logic [Z_W-1:0]         zi, ang;
    flag_t                  fi;
    logic                   vi;

    if (g == 0) begin : g_first
      assign xi = x_i;
      assign yi = y_i;
      assign zi = z_i;
      assign fi = flag_i;
      assign vi = valid_i;
    end else begin : g_next
      assign xi = x_q[g-1];
      assign yi = y_q[g-1];
      assign zi = z_q[g-1];
      assign fi = f_q[g-1];
      assign vi = v_q[g-1];
    end

    assign xs  = xi >>> g;
    assign ys  = yi >>> g;
    assign ang = atan_angle(5'(g));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!yi[CX_W-1]) begin
          x_q[g] <= xi + ys;
          y_q[g] <= yi - xs;
          z_q[g] <= zi + ang;
        end else begin
          x_q[g] <= xi - ys;
          y_q[g] <= yi + xs;
          z_q[g] <= zi - ang;
        end
        f_q[g] <= fi;
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign z_o     = z_q[STAGES-1];
  assign flag_o  = f_q[STAGES-1];

endmodule

// ----- sv/tilt_compensated_heading_core.sv -----
// Tilt compensated compass heading: top level with the cross products,
// projections, range scaling and output register. Depends on tch_pkg,
// tch_unorm and tch_cordic.
//
// Usage:
// - input channel (in_valid_i/in_ready_o) carries one accelerometer and one
//   magnetometer vector per transaction; output channel (out_valid_o/
//   out_ready_i) returns heading_o and degenerate_o for each of them in order
// - the front axis registers are written over the cfg channel (index 0..2
//   for x, y, z); cfg_ready_o is always high, index 3 is ignored; write them
//   only while no transaction is in flight
// - the pipe runs from the cross product register through 32 root stages,
//   the division and sign stages, the projection and scaling registers and
//   the cordic rotation stages to the output register
// - throughput is one transaction per cycle while the output is not stalled;
//   the root and quotient recurrences each retire one bit per stage
// - all stages advance together; when out_valid_o is high and out_ready_i
//   is low the whole pipe holds and in_ready_o goes low
// - reset clears all valid bits and loads the front axis with x = 16384
// - degenerate_o is set with heading 0 when the acceleration or the
//   magnetometer is zero or the magnetometer is parallel to the acceleration

module tilt_compensated_heading_core import tch_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] acc_x_i,
  input  logic signed [15:0] acc_y_i,
  input  logic signed [15:0] acc_z_i,
  input  logic signed [15:0] mag_x_i,
  input  logic signed [15:0] mag_y_i,
  input  logic signed [15:0] mag_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] heading_o,
  output logic               degenerate_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // front axis registers
  logic signed [15:0] front_x_q, front_y_q, front_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_x_q <= 16'sd16384;
      front_y_q <= '0;
      front_z_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRONT_X: front_x_q <= cfg_data_i;
        REG_FRONT_Y: front_y_q <= cfg_data_i;
        REG_FRONT_Z: front_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // east = m x a and |a|^2
  logic signed [E_W-1:0] ex_d, ey_d, ez_d;
  logic signed [31:0]    sq_x, sq_y, sq_z;
  logic [S_W-1:0]        ssq_d;

  assign ex_d = E_W'(mag_y_i * acc_z_i) - E_W'(mag_z_i * acc_y_i);
  assign ey_d = E_W'(mag_z_i * acc_x_i) - E_W'(mag_x_i * acc_z_i);
  assign ez_d = E_W'(mag_x_i * acc_y_i) - E_W'(mag_y_i * acc_x_i);
  assign sq_x = acc_x_i * acc_x_i;
  assign sq_y = acc_y_i * acc_y_i;
  assign sq_z = acc_z_i * acc_z_i;
  assign ssq_d = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

  logic               p1_v_q;
  side_t              p1_side_q;
  logic [S_W-1:0]     p1_ssq_q;
  logic signed [15:0] p1_ax_q, p1_ay_q, p1_az_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_side_q <= '{ex: ex_d, ey: ey_d, ez: ez_d,
                     deg: (ex_d == '0) && (ey_d == '0) && (ez_d == '0)};
      p1_ssq_q  <= ssq_d;
      p1_ax_q   <= acc_x_i;
      p1_ay_q   <= acc_y_i;
      p1_az_q   <= acc_z_i;
    end
  end

  // unit acceleration
  logic                  nm_v;
  logic signed [U_W-1:0] ux, uy, uz;
  side_t                 nm_side;

  tch_unorm u_unorm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (p1_v_q),
    .sum_sq_i (p1_ssq_q),
    .a_x_i    (p1_ax_q),
    .a_y_i    (p1_ay_q),
    .a_z_i    (p1_az_q),
    .side_i   (p1_side_q),
    .valid_o  (nm_v),
    .u_x_o    (ux),
    .u_y_o    (uy),
    .u_z_o    (uz),
    .side_o   (nm_side)
  );

  // north = u x east, and east projected on the front axis
  logic signed [N_W-2:0] pr_a [6];
  logic signed [N_W-1:0] nx_d, ny_d, nz_d, y0_d;

  assign pr_a[0] = uy * nm_side.ez;
  assign pr_a[1] = uz * nm_side.ey;
  assign pr_a[2] = uz * nm_side.ex;
  assign pr_a[3] = ux * nm_side.ez;
  assign pr_a[4] = ux * nm_side.ey;
  assign pr_a[5] = uy * nm_side.ex;
  assign nx_d = N_W'(pr_a[0]) - N_W'(pr_a[1]);
  assign ny_d = N_W'(pr_a[2]) - N_W'(pr_a[3]);
  assign nz_d = N_W'(pr_a[4]) - N_W'(pr_a[5]);
  assign y0_d = N_W'(nm_side.ex * front_x_q) + N_W'(nm_side.ey * front_y_q)
              + N_W'(nm_side.ez * front_z_q);

  logic                  p2_v_q, p2_deg_q;
  logic signed [N_W-1:0] p2_nx_q, p2_ny_q, p2_nz_q, p2_y0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= nm_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_nx_q  <= nx_d;
      p2_ny_q  <= ny_d;
      p2_nz_q  <= nz_d;
      p2_y0_q  <= y0_d;
      p2_deg_q <= nm_side.deg;
    end
  end

  // north projected on the front axis
  logic signed [XY_W-1:0] x_d, y_d;

  assign x_d = XY_W'(p2_nx_q) * XY_W'(front_x_q) + XY_W'(p2_ny_q) * XY_W'(front_y_q)
             + XY_W'(p2_nz_q) * XY_W'(front_z_q);
  assign y_d = XY_W'(p2_y0_q) <<< 15;

  logic                   p3_v_q, p3_deg_q;
  logic signed [XY_W-1:0] p3_x_q, p3_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (en) begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_x_q   <= x_d;
      p3_y_q   <= y_d;
      p3_deg_q <= p2_deg_q;
    end
  end

  // larger magnitude of the pair
  logic [XY_W-1:0] abs_x, abs_y;

  assign abs_x = p3_x_q[XY_W-1] ? $unsigned(-p3_x_q) : $unsigned(p3_x_q);
  assign abs_y = p3_y_q[XY_W-1] ? $unsigned(-p3_y_q) : $unsigned(p3_y_q);

  logic                   p4_v_q, p4_deg_q;
  logic signed [XY_W-1:0] p4_x_q, p4_y_q;
  logic [XY_W-1:0]        p4_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q <= 1'b0;
    end else if (en) begin
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_x_q   <= p3_x_q;
      p4_y_q   <= p3_y_q;
      p4_m_q   <= (abs_x > abs_y) ? abs_x : abs_y;
      p4_deg_q <= p3_deg_q;
    end
  end

  // leading one of the magnitude
  logic [5:0] lead_d;

  always_comb begin
    lead_d = '0;
    for (int i = 0; i < XY_W; i++) begin
      if (p4_m_q[i]) begin
        lead_d = 6'(i);
      end
    end
  end

  logic                   p5_v_q, p5_deg_q, p5_zero_q;
  logic signed [XY_W-1:0] p5_x_q, p5_y_q;
  logic [5:0]             p5_lead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
    end else if (en) begin
      p5_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_x_q    <= p4_x_q;
      p5_y_q    <= p4_y_q;
      p5_lead_q <= lead_d;
      p5_zero_q <= p4_m_q == '0;
      p5_deg_q  <= p4_deg_q;
    end
  end

  // bring the larger magnitude into [2^29, 2^30), then fold into the right half
  localparam logic [5:0] LeadTarget = 6'd29;

  logic signed [XY_W-1:0] xs_w, ys_w;
  logic signed [CX_W-1:0] xs_n, ys_n, cx_d, cy_d;
  logic [Z_W-1:0]         z0_d;

  always_comb begin
    if (p5_lead_q > LeadTarget) begin
      xs_w = p5_x_q >>> (p5_lead_q - LeadTarget);
      ys_w = p5_y_q >>> (p5_lead_q - LeadTarget);
    end else begin
      xs_w = p5_x_q <<< (LeadTarget - p5_lead_q);
      ys_w = p5_y_q <<< (LeadTarget - p5_lead_q);
    end
    xs_n = CX_W'(xs_w);
    ys_n = CX_W'(ys_w);
    if (xs_n[CX_W-1]) begin
      cx_d = -xs_n;
      cy_d = -ys_n;
      z0_d = Z_W'(1) << (Z_W - 1);
    end else begin
      cx_d = xs_n;
      cy_d = ys_n;
      z0_d = '0;
    end
  end

  logic                   p6_v_q;
  logic signed [CX_W-1:0] p6_x_q, p6_y_q;
  logic [Z_W-1:0]         p6_z_q;
  flag_t                  p6_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p6_v_q <= 1'b0;
    end else if (en) begin
      p6_v_q <= p5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p6_x_q <= cx_d;
      p6_y_q <= cy_d;
      p6_z_q <= z0_d;
      p6_f_q <= '{kill: p5_deg_q || p5_zero_q, deg: p5_deg_q};
    end
  end

  logic           cr_v;
  logic [Z_W-1:0] cr_z;
  flag_t          cr_f;

  tch_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p6_v_q),
    .x_i     (p6_x_q),
    .y_i     (p6_y_q),
    .z_i     (p6_z_q),
    .flag_i  (p6_f_q),
    .valid_o (cr_v),
    .z_o     (cr_z),
    .flag_o  (cr_f)
  );

  // heading = -z rounded to 16 bits
  logic [Z_W-1:0] hd_sum;
  logic           deg_q;
  logic [15:0]    heading_q;

  assign hd_sum = (Z_W'(0) - cr_z) + Z_W'(32'h8000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= cr_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      heading_q <= cr_f.kill ? 16'd0 : hd_sum[Z_W-1 -: 16];
      deg_q     <= cr_f.deg;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign heading_o    = heading_q;
  assign degenerate_o = deg_q;

endmodule

// ----- sv/tch_checker.sv -----
// tch_checker: port level assertions for the heading core, bound to the
// top level below. Depends on the port list of tilt_compensated_heading_core.

module tch_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] heading_o,
  input logic               degenerate_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o
);

  // pending result is not dropped while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output transaction dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(heading_o) && $stable(degenerate_o))
    else $error("output payload changed under stall");

  // the input side only backs up when the output is stalled
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without output stall");

  a_deg_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> heading_o == 16'sd0)
    else $error("degenerate result with nonzero heading");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind tilt_compensated_heading_core tch_checker u_tch_checker (.*);
